[rtl/mwo_pkg.sv]
// ----------------------------------------------------------------------------
// mwo_pkg
// Types and fixed constants of the multi-waveform oscillator: sequencer
// states, waveform select codes, configuration register indexes and the
// fixed-point constants of the sine table, saw scaling and noise LFSR.
// ----------------------------------------------------------------------------
`default_nettype none

package mwo_pkg;

  // Configuration port shape
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM   = 2'd1;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] STEP_RESET = 32'd42852281;

  // Noise generator: x^32 + x^22 + x^2 + x + 1, Galois form
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

  // pi/2 in unsigned Q30, used to build the quarter-wave sine table
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // 2/pi in Q24, final gain of the additive saw
  localparam logic signed [24:0] TWO_OVER_PI_Q24 = 25'sd10680707;

  // Guard bits kept on each harmonic before the divide by n
  localparam int SAW_GUARD_BITS = 8;

  // Waveform select codes
  typedef enum logic [2:0] {
    WAVE_SINE      = 3'd0,
    WAVE_SQUARE    = 3'd1,
    WAVE_TRIANGLE  = 3'd2,
    WAVE_ADD_SAW   = 3'd3,
    WAVE_ARITH_SAW = 3'd4,
    WAVE_NOISE     = 3'd5
  } wave_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_EVAL  = 3'd1,
    ST_SINE  = 3'd2,
    ST_SAW   = 3'd3,
    ST_SCALE = 3'd4,
    ST_ROUND = 3'd5,
    ST_FIN   = 3'd6
  } state_t;

endpackage

`default_nettype wire

[rtl/multi_waveform_oscillator.sv]
// ----------------------------------------------------------------------------
// multi_waveform_oscillator
// Direct digital synthesis audio oscillator: phase accumulator, quarter-wave
// sine ROM, square, triangle, additive (band-limited) saw, arithmetic saw
// and LFSR noise, with saturation to the signed sample range.
// ----------------------------------------------------------------------------
// Each input word with tick set advances the phase accumulator by phase_step
// and the noise LFSR by one step, then yields one signed Q1.(SAMPLE_BITS-1)
// sample of the selected waveform; a word with tick clear is taken and
// dropped. The block works on one word at a time and holds in_stall high
// while busy. Square, triangle, arithmetic saw and noise pass through the
// evaluate and finish states; sine adds a state for its registered sine ROM
// read. In the additive saw, one harmonic per cycle goes through a shared
// sine ROM read, reciprocal multiply and correction pipeline into the
// accumulator, followed by the 2/pi scale and rounding.
// A finished sample waits in the output register; the next input word is
// taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_waveform_oscillator
  import mwo_pkg::*;
#(
  parameter int HARMONICS       = 50,
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input words
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_tick,
  // result words
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_sample,
  output logic                               out_clipped,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int PB     = PHASE_BITS;
  localparam int SB     = SAMPLE_BITS;
  localparam int QN     = 1 << SINE_TABLE_BITS;
  localparam int ADDR_W = SINE_TABLE_BITS + 1;
  localparam int NB     = SB + SAW_GUARD_BITS;     // harmonic magnitude bits
  localparam int RCP_W  = NB + 1;                   // reciprocal width
  localparam int PRD_W  = NB + RCP_W;
  localparam int IDX_W  = $clog2(HARMONICS);
  localparam int CNT_W  = $clog2(HARMONICS + 1);
  localparam int QN_W   = NB + IDX_W;
  localparam int TERM_W = NB + 1;
  localparam int ACC_W  = SB + 11;
  localparam int SCL_W  = ACC_W + 25;
  localparam int V_W    = SB + 5;
  localparam int WD     = PB + SB;

  localparam int TRI_R = (PB - 2 >= SB - 1) ? (PB - 2) - (SB - 1) : 0;
  localparam int TRI_L = (PB - 2 >= SB - 1) ? 0 : (SB - 1) - (PB - 2);
  localparam int ASW_R = (PB >= SB) ? PB - SB : 0;
  localparam int ASW_L = (PB >= SB) ? 0 : SB - PB;

  localparam logic signed [V_W-1:0] FULL_V = V_W'(64'd1 << (SB - 1));
  localparam logic signed [V_W-1:0] MAX_V  = FULL_V - V_W'(1);
  localparam logic signed [V_W-1:0] MIN_V  = -FULL_V;

  // --------------------------------------------------------------------------
  // Quarter-wave sine table, built at elaboration with a Horner Taylor
  // series to x^13 in unsigned Q30
  // --------------------------------------------------------------------------
  typedef logic [SB-1:0] sine_tab_t [QN+1];

  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] one;
    one = 64'd1 << 30;
    for (int i = 0; i <= QN; i++) begin
      x  = (64'(i) * HALF_PI_Q30 + 64'(QN / 2)) >> SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      t  = one;
      t  = one - ((x2 * t) >> 30) / 64'd156;
      t  = one - ((x2 * t) >> 30) / 64'd110;
      t  = one - ((x2 * t) >> 30) / 64'd72;
      t  = one - ((x2 * t) >> 30) / 64'd42;
      t  = one - ((x2 * t) >> 30) / 64'd20;
      t  = one - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      tab[i] = SB'(((s << (SB - 1)) + (64'd1 << 29)) >> 30);
    end
    return tab;
  endfunction

  localparam sine_tab_t SIN_TAB = build_sine();

  // ROM address of a phase: mirror the index in odd quadrants
  function automatic logic [ADDR_W-1:0] sine_addr(input logic [PB-1:0] ph);
    logic [ADDR_W-1:0] idx;
    idx = {1'b0, ph[PB-3 -: SINE_TABLE_BITS]};
    return ph[PB-2] ? (ADDR_W'(QN) - idx) : idx;
  endfunction

  // --------------------------------------------------------------------------
  // Reciprocal table floor(2^NB / n) for the harmonic divide
  // --------------------------------------------------------------------------
  logic [RCP_W-1:0] rcp_tab [HARMONICS];

  for (genvar g = 0; g < HARMONICS; g++) begin : g_rcp
    localparam logic [RCP_W-1:0] RCP_V =
      RCP_W'((64'd1 << NB) / ((g == 0) ? 1 : g));
    assign rcp_tab[g] = RCP_V;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t                    state_r, state_nxt;
  logic [CFG_DATA_W-1:0]     step_r;
  wave_t                     wave_r;
  logic [PB-1:0]             phase_r, phase_nxt;
  logic [31:0]               lfsr_r, lfsr_nxt, lfsr_step;
  logic [PB-1:0]             ang_r, ang_nxt, ang_sum;
  logic [CNT_W-1:0]          n_r, n_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [SCL_W-1:0]   scl_r, scl_nxt;
  logic signed [V_W-1:0]     v_r, v_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SB-1:0]      out_sample_r, out_sample_nxt;
  logic                      out_clipped_r, out_clipped_nxt;

  // harmonic pipeline
  logic                      issue;
  logic [ADDR_W-1:0]         rom_addr;
  logic [SB-1:0]             rom_q_r;
  logic                      s1_v_r;
  logic                      s1_neg_r;
  logic [IDX_W-1:0]          s1_n_r;
  logic                      s2_v_r;
  logic                      s2_neg_r;
  logic [IDX_W-1:0]          s2_n_r;
  logic [NB-1:0]             s2_m_r;
  logic [PRD_W-1:0]          s2_prod_r;
  logic                      s3_v_r;
  logic signed [TERM_W-1:0]  s3_term_r;

  logic [NB-1:0]             harm_mag;
  logic [PRD_W-1:0]          harm_prod;
  logic [NB-1:0]             quo0;
  logic [NB-1:0]             quo;
  logic [QN_W-1:0]           quo_n;
  logic [QN_W-1:0]           rem;
  logic signed [TERM_W-1:0]  term;

  // waveform values
  logic [WD-1:0]             tri_w;
  logic [WD-1:0]             asw_w;
  logic signed [V_W-1:0]     tri_mag, tri_v;
  logic signed [V_W-1:0]     asw_v;
  logic signed [V_W-1:0]     noise_v;
  logic signed [V_W-1:0]     sine_mag, sine_v;
  logic [SCL_W-1:0]          rnd_mag, rnd_sum;
  logic signed [V_W-1:0]     rnd_v, round_v;
  logic                      saw_done;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
      wave_r <= WAVE_SINE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PHASE_STEP: step_r <= cfg_wdata;
        CFG_WAVEFORM:   wave_r <= wave_t'(cfg_wdata[2:0]);
        default:        ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Waveform values at the current phase
  // --------------------------------------------------------------------------
  always_comb begin
    lfsr_step = lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_TAPS) : (lfsr_r >> 1);

    // triangle: rescale the in-quadrant phase and fold by quadrant
    tri_w   = (WD'(phase_r[PB-3:0]) >> TRI_R) << TRI_L;
    tri_mag = $signed(V_W'(tri_w[SB-2:0]));
    case (phase_r[PB-1:PB-2])
      2'd0:    tri_v = tri_mag;
      2'd1:    tri_v = FULL_V - tri_mag;
      2'd2:    tri_v = -tri_mag;
      default: tri_v = tri_mag - FULL_V;
    endcase

    // arithmetic saw: top sample bits of the phase, recentered
    asw_w = (WD'(phase_r) >> ASW_R) << ASW_L;
    asw_v = $signed(V_W'(asw_w[SB-1:0])) - FULL_V;

    // noise: top sample bits of the LFSR, recentered
    noise_v = $signed(V_W'(lfsr_r[31 -: SB])) - FULL_V;

    // sine: ROM word read for the current phase, negated in the upper half
    sine_mag = $signed(V_W'(rom_q_r));
    sine_v   = phase_r[PB-1] ? -sine_mag : sine_mag;

    // additive saw: round the scaled sum half away from zero
    rnd_mag = scl_r[SCL_W-1] ? SCL_W'(-scl_r) : SCL_W'(scl_r);
    rnd_sum = rnd_mag + (SCL_W'(1) << 31);
    rnd_v   = $signed(V_W'(rnd_sum[SCL_W-1:32]));
    round_v = scl_r[SCL_W-1] ? -rnd_v : rnd_v;
  end

  // --------------------------------------------------------------------------
  // Harmonic pipeline: ROM read, reciprocal multiply, correct and sign
  // --------------------------------------------------------------------------
  assign issue    = (state_r == ST_SAW) && (n_r != CNT_W'(HARMONICS));
  assign ang_sum  = ang_r + phase_r;
  assign rom_addr = (state_r == ST_SAW) ? sine_addr(ang_sum) : sine_addr(phase_r);
  assign saw_done = !issue && !s1_v_r && !s2_v_r && !s3_v_r;

  always_comb begin
    harm_mag  = {rom_q_r, {SAW_GUARD_BITS{1'b0}}};
    harm_prod = harm_mag * rcp_tab[s1_n_r];
    // the reciprocal estimate is low by at most one
    quo0  = s2_prod_r[NB +: NB];
    quo_n = quo0 * s2_n_r;
    rem   = QN_W'(s2_m_r) - quo_n;
    quo   = (rem >= QN_W'(s2_n_r)) ? quo0 + NB'(1) : quo0;
    term  = s2_neg_r ? -$signed(TERM_W'(quo)) : $signed(TERM_W'(quo));
  end

  always_ff @(posedge clk) begin
    rom_q_r   <= SIN_TAB[rom_addr];
    s1_neg_r  <= ang_sum[PB-1];
    s1_n_r    <= n_r[IDX_W-1:0];
    s2_neg_r  <= s1_neg_r;
    s2_n_r    <= s1_n_r;
    s2_m_r    <= harm_mag;
    s2_prod_r <= harm_prod;
    s3_term_r <= term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state and datapath controls
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    lfsr_nxt        = lfsr_r;
    ang_nxt         = ang_r;
    n_nxt           = n_r;
    acc_nxt         = acc_r;
    scl_nxt         = scl_r;
    v_nxt           = v_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_sample_nxt  = out_sample_r;
    out_clipped_nxt = out_clipped_r;

    // accumulate each finished harmonic term
    if (s3_v_r) begin
      acc_nxt = acc_r + ACC_W'(s3_term_r);
    end

    unique case (state_r)
      ST_IDLE: begin
        // take a word; only a tick advances the oscillator
        if (in_valid && in_tick) begin
          phase_nxt = phase_r + PB'(step_r);
          lfsr_nxt  = lfsr_step;
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        state_nxt = ST_FIN;
        unique case (wave_r)
          WAVE_SINE: begin
            state_nxt = ST_SINE;
          end
          WAVE_SQUARE: begin
            v_nxt = ((phase_r != '0) && !phase_r[PB-1]) ? FULL_V : MIN_V;
          end
          WAVE_TRIANGLE: begin
            v_nxt = tri_v;
          end
          WAVE_ADD_SAW: begin
            ang_nxt   = '0;
            n_nxt     = CNT_W'(1);
            acc_nxt   = '0;
            state_nxt = ST_SAW;
          end
          WAVE_ARITH_SAW: begin
            v_nxt = asw_v;
          end
          WAVE_NOISE: begin
            v_nxt = noise_v;
          end
          default: begin
            v_nxt = '0;
          end
        endcase
      end

      ST_SINE: begin
        v_nxt     = sine_v;
        state_nxt = ST_FIN;
      end

      ST_SAW: begin
        // issue one harmonic per cycle, then drain the pipeline
        if (issue) begin
          ang_nxt = ang_sum;
          n_nxt   = n_r + CNT_W'(1);
        end
        if (saw_done) begin
          state_nxt = ST_SCALE;
        end
      end

      ST_SCALE: begin
        scl_nxt   = acc_r * TWO_OVER_PI_Q24;
        state_nxt = ST_ROUND;
      end

      ST_ROUND: begin
        v_nxt     = round_v;
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        // saturate into the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (v_r > MAX_V) begin
            out_sample_nxt  = MAX_V[SB-1:0];
            out_clipped_nxt = 1'b1;
          end else if (v_r < MIN_V) begin
            out_sample_nxt  = MIN_V[SB-1:0];
            out_clipped_nxt = 1'b1;
          end else begin
            out_sample_nxt  = v_r[SB-1:0];
            out_clipped_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control and oscillator state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      lfsr_r      <= LFSR_SEED;
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
    end
  end

  // Working and output payload
  always_ff @(posedge clk) begin
    ang_r         <= ang_nxt;
    acc_r         <= acc_nxt;
    scl_r         <= scl_nxt;
    v_r           <= v_nxt;
    out_sample_r  <= out_sample_nxt;
    out_clipped_r <= out_clipped_nxt;
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_clipped = out_clipped_r;

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-waveform oscillator. A behavioral model
// of the phase accumulator, noise LFSR and all six waveforms predicts every
// sample word. Directed tests cover the quadrant corners, the square edge at
// phase zero, full-scale clipping, spare codes and dropped words. A random
// sweep then follows, with idle bursts on the input and stall bursts on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mwo_pkg::*;

  localparam int HARMONICS       = 50;
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  localparam int TABLE_SIZE = 1 << SINE_TABLE_BITS;
  localparam longint FULL_SCALE = longint'(1) << (SAMPLE_BITS - 1);
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  // Register indexes and waveform codes the block ignores or maps to silence
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [2:0] WAVE_SPARE_6 = 3'd6;
  localparam logic [2:0] WAVE_SPARE_7 = 3'd7;

  localparam logic [PHASE_BITS-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [PHASE_BITS-1:0] HALF_TURN    = 32'h8000_0000;

  localparam int SETTLE_CYCLES    = HARMONICS + 14;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TICK_TARGET      = 1650;
  localparam int CALM_TAIL        = 300;
  localparam int REPORT_LIMIT     = 10;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clipped;
  } sample_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_tick = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic out_clipped;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PHASE_STEP;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Oscillator model state and settings
  logic [PHASE_BITS-1:0] model_step = STEP_RESET[PHASE_BITS-1:0];
  logic [PHASE_BITS-1:0] model_phase = '0;
  logic [31:0] model_lfsr = LFSR_SEED;
  logic [2:0] model_wave = WAVE_SINE;
  longint sine_rom [0:TABLE_SIZE];

  sample_word_t pending_samples[$];
  int error_count = 0;
  int ticks_sent = 0;
  int quiet_cycles = 0;
  int hold_request = 0;
  bit idle_on = 1'b1;

  multi_waveform_oscillator #(
    .HARMONICS      (HARMONICS),
    .PHASE_BITS     (PHASE_BITS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_tick    (in_tick),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .out_clipped(out_clipped),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Build the quarter-wave table: Taylor series to x^13 in Q30, Horner form
  initial begin : build_sine_rom
    longint unsigned idx, x, x2, t, s, div;
    int k;
    for (idx = 0; idx <= TABLE_SIZE; idx++) begin
      x = (idx * HALF_PI_Q30 + 64'(TABLE_SIZE / 2)) >> SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      t = ONE_Q30;
      for (k = 0; k < 6; k++) begin
        div = (13 - 2 * k) * (12 - 2 * k);
        t = ONE_Q30 - ((x2 * t) >> 30) / div;
      end
      s = (x * t) >> 30;
      sine_rom[idx] = longint'(((s << (SAMPLE_BITS - 1)) + (ONE_Q30 >> 1)) >> 30);
    end
  end

  // Look up the sine at a phase, mirroring the quarter table per quadrant
  function automatic longint sine_lookup(input logic [PHASE_BITS-1:0] ph);
    logic [1:0] quad;
    int slot;
    quad = ph[PHASE_BITS-1 -: 2];
    slot = int'(ph[PHASE_BITS-3 -: SINE_TABLE_BITS]);
    case (quad)
      2'd0: return sine_rom[slot];
      2'd1: return sine_rom[TABLE_SIZE - slot];
      2'd2: return -sine_rom[slot];
      default: return -sine_rom[TABLE_SIZE - slot];
    endcase
  endfunction

  // Advance phase and LFSR by one tick and compute the sample word
  function automatic sample_word_t advance_oscillator();
    longint level, acc, prod;
    logic [PHASE_BITS-1:0] ang;
    int n;
    sample_word_t word;
    model_phase = model_phase + model_step;
    model_lfsr = model_lfsr[0] ? ((model_lfsr >> 1) ^ LFSR_TAPS) : (model_lfsr >> 1);
    word.clipped = 1'b0;
    case (model_wave)
      WAVE_SINE: level = sine_lookup(model_phase);
      WAVE_SQUARE: begin
        level = (model_phase != '0 && !model_phase[PHASE_BITS-1]) ? FULL_SCALE : -FULL_SCALE;
      end
      WAVE_TRIANGLE: begin
        level = longint'(model_phase[PHASE_BITS-3 -: SAMPLE_BITS-1]);
        case (model_phase[PHASE_BITS-1 -: 2])
          2'd1: level = FULL_SCALE - level;
          2'd2: level = -level;
          2'd3: level = level - FULL_SCALE;
          default: ;
        endcase
      end
      WAVE_ADD_SAW: begin
        // sum sin(n*phase)/n with guard bits, truncating each term toward zero
        acc = 0;
        ang = '0;
        for (n = 1; n < HARMONICS; n++) begin
          ang = ang + model_phase;
          acc = acc + (sine_lookup(ang) * (longint'(1) << SAW_GUARD_BITS)) / n;
        end
        prod = acc * longint'(TWO_OVER_PI_Q24);
        if (prod >= 0) begin
          level = (prod + (longint'(1) << 31)) >>> 32;
        end else begin
          level = -((-prod + (longint'(1) << 31)) >>> 32);
        end
      end
      WAVE_ARITH_SAW: level = longint'(model_phase[PHASE_BITS-1 -: SAMPLE_BITS]) - FULL_SCALE;
      WAVE_NOISE: level = longint'(model_lfsr[31 -: SAMPLE_BITS]) - FULL_SCALE;
      default: level = 0;
    endcase
    if (level > FULL_SCALE - 1) begin
      level = FULL_SCALE - 1;
      word.clipped = 1'b1;
    end else if (level < -FULL_SCALE) begin
      level = -FULL_SCALE;
      word.clipped = 1'b1;
    end
    word.sample = level[SAMPLE_BITS-1:0];
    return word;
  endfunction

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("mismatch at %0t ns: %s", $realtime, msg);
    end
  endfunction

  // Compare each result word against the oldest pending sample
  always @(posedge clk) begin : check_results
    sample_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        flag_error($sformatf("result word with nothing pending: sample %0d clipped %0b",
                             out_sample, out_clipped));
      end else begin
        want = pending_samples.pop_front();
        if (out_sample !== want.sample) begin
          flag_error($sformatf("sample: expected %0d, got %0d",
                               $signed(want.sample), out_sample));
        end
        if (out_clipped !== want.clipped) begin
          flag_error($sformatf("clipped: expected %0b, got %0b", want.clipped, out_clipped));
        end
      end
    end
  end

  // Receiver: honor a requested long hold, else stall in random bursts
  initial begin : result_receiver
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        out_stall <= 1'b1;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Drop the run when neither channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Offer one word, after an optional idle burst; valid stays high on return
  task automatic send_word(input logic tick_bit);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tick <= tick_bit;
    do @(posedge clk); while (in_stall);
    if (tick_bit) begin
      pending_samples.push_back(advance_oscillator());
      ticks_sent++;
    end
  endtask

  // Drop valid, wait for every pending sample, then let a dropped word finish
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PHASE_STEP: model_step = value[PHASE_BITS-1:0];
      CFG_WAVEFORM: model_wave = value[2:0];
      default: ;
    endcase
  endtask

  // Land the accumulator exactly on a target phase with one tick
  task automatic steer_phase(input logic [PHASE_BITS-1:0] target);
    write_reg(CFG_PHASE_STEP, target - model_phase);
    send_word(1'b1);
  endtask

  task automatic test_reset_state();
    repeat (2) send_word(1'b1);
  endtask

  task automatic test_dropped_words();
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b1);
  endtask

  task automatic test_sine_quadrants();
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SINE));
    steer_phase('0);
    // peak clips, then zero, negative full scale, zero
    write_reg(CFG_PHASE_STEP, QUARTER_TURN);
    repeat (4) send_word(1'b1);
  endtask

  task automatic test_square_edges();
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SQUARE));
    // half turn is low, and so is the wrap back to phase zero
    write_reg(CFG_PHASE_STEP, HALF_TURN);
    repeat (2) send_word(1'b1);
    write_reg(CFG_PHASE_STEP, 32'd1);
    send_word(1'b1);
    write_reg(CFG_PHASE_STEP, HALF_TURN - 32'd2);
    send_word(1'b1);
  endtask

  task automatic test_triangle_corners();
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_TRIANGLE));
    steer_phase('0);
    write_reg(CFG_PHASE_STEP, QUARTER_TURN);
    repeat (4) send_word(1'b1);
  endtask

  task automatic test_saw_and_noise();
    // small phase sits in the overshoot of the band-limited saw
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_ADD_SAW));
    steer_phase(32'h0100_0000);
    steer_phase(32'hC000_0000);
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_ARITH_SAW));
    write_reg(CFG_PHASE_STEP, '1);
    repeat (2) send_word(1'b1);
    // zero step holds the phase while the LFSR keeps running
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_NOISE));
    write_reg(CFG_PHASE_STEP, '0);
    repeat (2) send_word(1'b1);
  endtask

  task automatic test_spare_codes();
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SPARE_6));
    send_word(1'b1);
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SPARE_7));
    send_word(1'b1);
    // writes to unused indexes must leave step and waveform alone
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_ARITH_SAW));
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, 32'h1234_5678);
    send_word(1'b1);
  endtask

  task automatic test_backpressure();
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SQUARE));
    write_reg(CFG_PHASE_STEP, $urandom());
    hold_request = LONG_HOLD_CYCLES;
    repeat (40) send_word($urandom_range(0, 7) != 0);
    // pause the sender until every pending sample is back, then resume
    wait_drained();
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_NOISE));
    repeat (30) send_word($urandom_range(0, 7) != 0);
  endtask

  task automatic test_random_sweep();
    int round, burst, sent;
    logic tick_bit;
    logic [2:0] wave_pick;
    logic [CFG_DATA_W-1:0] step_pick;
    round = 0;
    while (ticks_sent < TICK_TARGET) begin
      if (TICK_TARGET - ticks_sent < CALM_TAIL) begin
        idle_on = 1'b0;
      end
      // walk all codes once, then pick at random; upper data bits are junk
      wave_pick = (round < 8) ? 3'(round) : 3'($urandom_range(0, 7));
      write_reg(CFG_WAVEFORM, {29'($urandom()), wave_pick});
      case ($urandom_range(0, 7))
        0: step_pick = '0;
        1: step_pick = '1;
        2: step_pick = 32'd1;
        3: step_pick = HALF_TURN;
        4: step_pick = $urandom_range(1, 1 << 20);
        5: step_pick = STEP_RESET;
        default: step_pick = $urandom();
      endcase
      write_reg(CFG_PHASE_STEP, step_pick);
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom());
      end
      burst = $urandom_range(40, 120);
      sent = 0;
      while (sent < burst) begin
        tick_bit = ($urandom_range(0, 7) != 0);
        send_word(tick_bit);
        if (tick_bit) begin
          sent++;
        end
      end
      round++;
    end
  endtask

  initial begin : run_tests
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_dropped_words();
    test_sine_quadrants();
    test_square_edges();
    test_triangle_corners();
    test_saw_and_noise();
    test_spare_codes();
    test_backpressure();
    test_random_sweep();
    wait_drained();
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
